[design/ldnf_pkg.sv]
// ----------------------------------------------------------------------------
// ldnf_pkg: shared types and constants of the LCD decimal number formatter
// Holds the item word that moves down the pipeline and the character codes.
// ----------------------------------------------------------------------------
package ldnf_pkg;

   // Decimal conversion: four divide-by-ten stages, the fifth digit is the
   // final quotient.
   localparam int NUM_DIV_STAGES = 4;
   localparam int MAX_BYTES      = 8;
   localparam int IDX_W          = $clog2(MAX_BYTES);
   localparam int CNT_W          = IDX_W + 1;

   // Reciprocal of ten: x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x.
   localparam logic [15:0] RECIP_TEN   = 16'hCCCD;
   localparam int          RECIP_SHIFT = 19;

   // Position command
   localparam logic [7:0] COL_MAX      = 8'd20;
   localparam logic [7:0] ROW_MAX      = 8'd4;
   localparam logic [7:0] ADD_ROW_TWO  = 8'd44;
   localparam logic [7:0] SUB_ROW_THREE = 8'd20;
   localparam logic [7:0] ADD_ROW_FOUR = 8'd24;
   localparam logic [7:0] SET_POS_CMD  = 8'h80;

   // Characters
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   // Word carried between pipeline stages
   typedef struct packed {
      logic [7:0]                     cmd;
      logic                           framed;
      logic                           neg;
      logic [15:0]                    quot;
      logic [NUM_DIV_STAGES-1:0][3:0] digits;
   } ldnf_item_type;

endpackage

[design/lcd_decimal_number_formatter_top.sv]
// ----------------------------------------------------------------------------
// lcd_decimal_number_formatter_top: decimal number formatter for a 20x4 LCD
// Turns a column, a row and a signed value into the LCD byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel takes one word: column, row and a signed 16-bit value.
//   rsp_ channel gives one LCD byte per word, tagged command or data, with
//   rsp_last on the final byte of each request.
//   A request yields 1 to 8 bytes: an optional set-position command, an
//   optional '-', the digits without leading zeros, an optional space.
//   The first byte passes the input stage, the four divide-by-ten stages
//   and the byte buffer, each a register, before it is offered.
//   The output gives one byte per cycle while rsp_ready is high; the byte
//   buffer is the limiting unit. Pipeline stages fill while bytes still
//   drain, and the next request loads as the last byte of the previous one
//   leaves.
//   Reset empties every stage; no bytes are pending afterward.
//   When rsp_ready is low the current byte holds and the pipeline stalls
//   stage by stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lcd_decimal_number_formatter_top
   import ldnf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_column,
   input  logic [7:0]         req_row,
   input  logic signed [15:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_lcd_byte,
   output logic               rsp_is_data,
   output logic               rsp_last
);

   logic          stage_valid [NUM_DIV_STAGES+1];
   logic          stage_ready [NUM_DIV_STAGES+1];
   ldnf_item_type stage_item  [NUM_DIV_STAGES+1];

   // Sign, magnitude and position command
   ldnf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_column (req_column),
      .in_row    (req_row),
      .in_value  (req_value),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_item  (stage_item[0])
   );

   // Binary to decimal, one digit per stage, least significant first
   for (genvar g = 0; g < NUM_DIV_STAGES; g++) begin : g_div
      ldnf_div10 #(
         .DIGIT_IDX (g)
      ) u_div10 (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_ready  (stage_ready[g]),
         .in_item   (stage_item[g]),
         .out_valid (stage_valid[g+1]),
         .out_ready (stage_ready[g+1]),
         .out_item  (stage_item[g+1])
      );
   end

   // Byte layout and output
   ldnf_serializer u_serializer (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (stage_valid[NUM_DIV_STAGES]),
      .in_ready     (stage_ready[NUM_DIV_STAGES]),
      .in_item      (stage_item[NUM_DIV_STAGES]),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_lcd_byte (rsp_lcd_byte),
      .rsp_is_data  (rsp_is_data),
      .rsp_last     (rsp_last)
   );

endmodule

[design/ldnf_front.sv]
// ----------------------------------------------------------------------------
// ldnf_front: input stage
// Builds the set-position command, the sign and the magnitude of the value.
// ----------------------------------------------------------------------------
module ldnf_front
   import ldnf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           in_column,
   input  logic [7:0]           in_row,
   input  logic signed [15:0]   in_value,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ldnf_item_type        out_item
);

   logic          valid_ff, valid_in;
   ldnf_item_type item_ff, item_in;
   logic [7:0]    col_c, row_c, row_m1, addr, addr_adj;
   logic          neg;

   // Clamp and map the cursor position, 8-bit wraparound throughout
   always_comb begin
      col_c  = (in_column > COL_MAX) ? COL_MAX : in_column;
      row_c  = (in_row > ROW_MAX) ? ROW_MAX : in_row;
      row_m1 = row_c - 8'd1;
      addr   = col_c + (row_m1 << 4) + (row_m1 << 2);
      case (addr) inside
         [8'd21:8'd40]: addr_adj = addr + ADD_ROW_TWO;
         [8'd41:8'd60]: addr_adj = addr - SUB_ROW_THREE;
         [8'd61:8'd80]: addr_adj = addr + ADD_ROW_FOUR;
         default:       addr_adj = addr;
      endcase
   end

   // Assemble the word for the conversion stages
   always_comb begin
      neg            = in_value[15];
      item_in        = '0;
      item_in.cmd    = (addr_adj - 8'd1) | SET_POS_CMD;
      item_in.neg    = neg;
      item_in.framed = neg || (in_column != 8'd0);
      item_in.quot   = neg ? (16'd0 - in_value) : in_value;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the word while the next stage stalls
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

[design/ldnf_div10.sv]
// ----------------------------------------------------------------------------
// ldnf_div10: one divide-by-ten stage
// Divides the running quotient by ten and stores the remainder as a digit.
// ----------------------------------------------------------------------------
module ldnf_div10
   import ldnf_pkg::*;
#(
   parameter int DIGIT_IDX = 0
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  ldnf_item_type in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output ldnf_item_type out_item
);

   logic          valid_ff, valid_in;
   ldnf_item_type item_ff, item_in;
   logic [31:0]   prod;
   logic [15:0]   quot, rem;

   // Multiply by the reciprocal, then recover the remainder by shift-add
   always_comb begin
      prod    = 32'(in_item.quot) * 32'(RECIP_TEN);
      quot    = 16'(prod[31:RECIP_SHIFT]);
      rem     = in_item.quot - ((quot << 3) + (quot << 1));
      item_in = in_item;
      item_in.quot = quot;
      item_in.digits[DIGIT_IDX] = rem[3:0];
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Advance the word only when the stage is free
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

[design/ldnf_serializer.sv]
// ----------------------------------------------------------------------------
// ldnf_serializer: byte packing and output stage
// Lays out the bytes of one item and hands them out one word per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module ldnf_serializer
   import ldnf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  ldnf_item_type in_item,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_lcd_byte,
   output logic          rsp_is_data,
   output logic          rsp_last
);

   logic [MAX_BYTES-1:0][7:0] bytes_ff, bytes_in;
   logic [MAX_BYTES-1:0]      data_ff, data_in;
   logic [IDX_W-1:0]          last_ff, last_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic                      valid_ff, valid_in;
   logic [4:0][3:0]           dig;
   logic [2:0]                ndig;
   logic [CNT_W-1:0]          k;
   logic                      fire, done, load;

   // Count digits with leading zeros suppressed
   always_comb begin
      dig = {in_item.quot[3:0], in_item.digits};
      if (dig[4] != 4'd0) begin
         ndig = 3'd5;
      end else if (dig[3] != 4'd0) begin
         ndig = 3'd4;
      end else if (dig[2] != 4'd0) begin
         ndig = 3'd3;
      end else if (dig[1] != 4'd0) begin
         ndig = 3'd2;
      end else begin
         ndig = 3'd1;
      end
   end

   // Lay out command, sign, digits and trailing space
   always_comb begin
      bytes_in = '0;
      data_in  = '0;
      k        = '0;
      if (in_item.framed) begin
         bytes_in[k[IDX_W-1:0]] = in_item.cmd;
         data_in[k[IDX_W-1:0]]  = 1'b0;
         k = k + 1'b1;
      end
      if (in_item.neg) begin
         bytes_in[k[IDX_W-1:0]] = CHAR_MINUS;
         data_in[k[IDX_W-1:0]]  = 1'b1;
         k = k + 1'b1;
      end
      for (int i = 4; i >= 0; i--) begin
         if (3'(i) < ndig) begin
            bytes_in[k[IDX_W-1:0]] = CHAR_ZERO | {4'd0, dig[i]};
            data_in[k[IDX_W-1:0]]  = 1'b1;
            k = k + 1'b1;
         end
      end
      if (in_item.framed) begin
         bytes_in[k[IDX_W-1:0]] = CHAR_SPACE;
         data_in[k[IDX_W-1:0]]  = 1'b1;
         k = k + 1'b1;
      end
      last_in = IDX_W'(k - 1'b1);
   end

   // Step through the bytes; take a new item as the last byte leaves
   assign fire     = valid_ff && rsp_ready;
   assign done     = fire && (idx_ff == last_ff);
   assign in_ready = !valid_ff || done;
   assign load     = in_valid && in_ready;
   assign valid_in = load ? 1'b1 : (done ? 1'b0 : valid_ff);
   assign idx_in   = load ? '0 : (fire ? idx_ff + 1'b1 : idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= bytes_in;
         data_ff  <= data_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_lcd_byte = bytes_ff[idx_ff];
   assign rsp_is_data  = data_ff[idx_ff];
   assign rsp_last     = (idx_ff == last_ff);

endmodule

[design/ldnf_checker.sv]
// ----------------------------------------------------------------------------
// ldnf_checker: port-level checks of the formatter
// Watches the result channel for byte-stream rules and holds under stall.
// ----------------------------------------------------------------------------
module ldnf_checker
   import ldnf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [7:0]         rsp_lcd_byte,
   input logic               rsp_is_data,
   input logic               rsp_last
);

   // Stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lcd_byte)
         && $stable(rsp_is_data) && $stable(rsp_last))
      else $error("result word changed under stall");

   // A position command always has the set-position bit
   a_cmd_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_data |-> rsp_lcd_byte[7])
      else $error("command without set-position bit");

   // A command is never the final byte
   a_cmd_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_data |-> !rsp_last)
      else $error("command marked last");

   // A minus sign is never the final byte
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_data && (rsp_lcd_byte == CHAR_MINUS) |-> !rsp_last)
      else $error("minus sign marked last");

endmodule

bind lcd_decimal_number_formatter_top ldnf_checker u_ldnf_checker (.*);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lcd_decimal_number_formatter_top
// Sends column/row/value words, predicts the LCD byte stream of each one and
// compares every byte that leaves the block, with random gaps on both sides
// and one long output stall that backs the pipeline up to its input.
// ----------------------------------------------------------------------------
module testbench;
   import ldnf_pkg::*;

   // Own copies of the display constants used by the predictor
   localparam logic [7:0] LCD_COLS     = 8'd20;
   localparam logic [7:0] LCD_ROWS     = 8'd4;
   localparam logic [7:0] SET_DDRAM    = 8'h80;
   localparam logic [7:0] ASCII_MINUS  = 8'h2D;
   localparam logic [7:0] ASCII_SPACE  = 8'h20;
   localparam logic [7:0] ASCII_ZERO   = 8'h30;
   localparam int         DRAIN_WAIT   = 20;
   localparam int         HOLD_CYCLES  = 200;

   typedef struct {
      logic [7:0] code;
      logic       is_data;
      logic       last;
   } lcd_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_column = '0;
   logic [7:0]         req_row = '0;
   logic signed [15:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_lcd_byte;
   logic               rsp_is_data;
   logic               rsp_last;

   lcd_word_type pending_bytes[$];
   int           errors = 0;
   bit           sender_idles = 1'b1;
   bit           sink_idles = 1'b1;
   bit           hold_requested = 1'b0;

   lcd_decimal_number_formatter_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_column   (req_column),
      .req_row      (req_row),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_lcd_byte (rsp_lcd_byte),
      .rsp_is_data  (rsp_is_data),
      .rsp_last     (rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Cursor address for the 20x4 panel, all in 8-bit wrapping arithmetic
   function automatic logic [7:0] cursor_command(input logic [7:0] col,
                                                 input logic [7:0] row);
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] addr;
      x = (col > LCD_COLS) ? LCD_COLS : col;
      y = (row > LCD_ROWS) ? LCD_ROWS : row;
      addr = x + (y - 8'd1) * 8'd20;
      if (addr >= 8'd21 && addr <= 8'd40)
         addr = addr + 8'd44;
      else if (addr >= 8'd41 && addr <= 8'd60)
         addr = addr - 8'd20;
      else if (addr >= 8'd61 && addr <= 8'd80)
         addr = addr + 8'd24;
      addr = addr - 8'd1;
      return addr | SET_DDRAM;
   endfunction

   // Queue the LCD bytes that one number word produces
   function automatic void predict_lcd_bytes(input logic [7:0] col,
                                             input logic [7:0] row,
                                             input logic [15:0] val);
      logic         neg;
      logic         framed;
      logic [15:0]  mag;
      int           digit [5];
      int           first;
      lcd_word_type w;
      lcd_word_type line [$];
      neg = val[15];
      mag = neg ? (~val + 16'd1) : val;
      framed = neg || (col != 8'd0);
      for (int i = 4; i >= 0; i--) begin
         digit[i] = mag % 10;
         mag = mag / 10;
      end
      first = 0;
      while (first < 4 && digit[first] == 0)
         first++;
      w.last = 1'b0;
      if (framed) begin
         w.code = cursor_command(col, row);
         w.is_data = 1'b0;
         line.push_back(w);
      end
      w.is_data = 1'b1;
      if (neg) begin
         w.code = ASCII_MINUS;
         line.push_back(w);
      end
      for (int i = first; i < 5; i++) begin
         w.code = ASCII_ZERO + 8'(digit[i]);
         line.push_back(w);
      end
      if (framed) begin
         w.code = ASCII_SPACE;
         line.push_back(w);
      end
      line[line.size() - 1].last = 1'b1;
      foreach (line[i])
         pending_bytes.push_back(line[i]);
   endfunction

   // Offer one word; called at a falling edge, returns at a falling edge
   task automatic send_number(input logic [7:0] col, input logic [7:0] row,
                              input logic [15:0] val);
      int gap;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_column <= col;
      req_row    <= row;
      req_value  <= val;
      do
         @(posedge clock);
      while (!req_ready);
      predict_lcd_bytes(col, row, val);
      @(negedge clock);
   endtask

   // Receiver: ready and stall bursts, plus one long hold on request
   initial begin
      int  n;
      bit  v;
      while (reset) @(negedge clock);
      forever begin
         if (hold_requested) begin
            v = 1'b0;
            n = HOLD_CYCLES;
         end else if (sink_idles) begin
            v = $urandom_range(0, 2) != 0;
            n = $urandom_range(1, 13);
         end else begin
            v = 1'b1;
            n = 1;
         end
         rsp_ready <= v;
         repeat (n) @(negedge clock);
         if (!v && n == HOLD_CYCLES)
            hold_requested = 1'b0;
      end
   end

   // Compare each accepted byte with the oldest prediction
   always @(posedge clock) begin
      lcd_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_bytes.size() == 0) begin
            $error("unexpected LCD byte %h (is_data %b, last %b)",
                   rsp_lcd_byte, rsp_is_data, rsp_last);
            errors++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_lcd_byte !== want.code) begin
               $error("lcd_byte: expected %h, actual %h", want.code, rsp_lcd_byte);
               errors++;
            end
            if (rsp_is_data !== want.is_data) begin
               $error("is_data: expected %b, actual %b", want.is_data, rsp_is_data);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %b, actual %b", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // Random number word with a bias toward short and boundary values
   task automatic send_random_number();
      logic [7:0]  col;
      logic [7:0]  row;
      int          mag;
      logic [15:0] val;
      case ($urandom_range(0, 7))
         0, 1:    col = 8'd0;
         2:       col = 8'($urandom_range(21, 255));
         default: col = 8'($urandom_range(1, 20));
      endcase
      row = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 5));
      case ($urandom_range(0, 4))
         0:       mag = $urandom_range(0, 9);
         1:       mag = $urandom_range(0, 999);
         2:       mag = 10 ** $urandom_range(0, 4) - $urandom_range(0, 1);
         3:       mag = $urandom_range(32760, 32768);
         default: mag = $urandom_range(0, 32768);
      endcase
      if (mag > 32767 || $urandom_range(0, 1) == 1)
         val = 16'(-mag);
      else
         val = 16'(mag);
      send_number(col, row, val);
   endtask

   // Field extremes, clamping, row zero, column zero, zero and most negative
   task automatic test_directed();
      send_number(8'd0, 8'd1, 16'd0);
      send_number(8'd0, 8'd1, 16'd7);
      send_number(8'd0, 8'd2, 16'sd32767);
      send_number(8'd0, 8'd3, -16'sd1);
      send_number(8'd0, 8'd0, -16'sd42);
      send_number(8'd1, 8'd1, 16'd0);
      send_number(8'd20, 8'd1, 16'd9);
      send_number(8'd1, 8'd2, 16'd10);
      send_number(8'd20, 8'd2, 16'd99);
      send_number(8'd1, 8'd3, 16'd100);
      send_number(8'd20, 8'd3, 16'd999);
      send_number(8'd1, 8'd4, 16'd1000);
      send_number(8'd20, 8'd4, 16'd9999);
      send_number(8'd21, 8'd4, 16'd10000);
      send_number(8'd255, 8'd255, 16'sh8000);
      send_number(8'd5, 8'd5, 16'sh8001);
      send_number(8'd5, 8'd0, 16'd12345);
      send_number(8'd20, 8'd0, -16'sd9);
      send_number(8'd1, 8'd0, 16'd1);
      send_number(8'd128, 8'd127, 16'shFFFF);
      send_number(8'd0, 8'd255, 16'sh8000);
      send_number(8'd10, 8'd2, 16'h5555);
      send_number(8'd11, 8'd3, 16'haaaa);
   endtask

   task automatic test_random_numbers();
      repeat (300) send_random_number();
   endtask

   // Hold the output off while words keep coming so the input stalls
   task automatic test_output_backpressure();
      hold_requested = 1'b1;
      sender_idles = 1'b0;
      repeat (20) send_random_number();
      sender_idles = 1'b1;
   endtask

   // Last part: no idling on either side
   task automatic test_full_rate();
      sender_idles = 1'b0;
      sink_idles = 1'b0;
      repeat (40) send_random_number();
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_numbers();
      test_output_backpressure();
      test_full_rate();
      req_valid <= 1'b0;
      wait (pending_bytes.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog
   initial begin
      #3200000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[lcd_decimal_number_formatter_top.f]
design/ldnf_pkg.sv
design/ldnf_front.sv
design/ldnf_div10.sv
design/ldnf_serializer.sv
design/lcd_decimal_number_formatter_top.sv
design/ldnf_checker.sv
dv/testbench.sv
